// ===== design/c3ef_pkg.sv =====
// Shared types and constants for the 3x3 replicate-border convolution filter.
// No dependencies; imported by the window, MAC and top-level modules.
package c3ef_pkg;

    localparam int KSIZE = 3;
    localparam int TAPS = KSIZE * KSIZE;
    localparam int OUT_BITS = 28;
    localparam int COEF_SLOT = 16;
    localparam int KROW_BITS = 48;
    localparam int IMG_W_BITS = 11;
    localparam int IMG_H_BITS = 16;

    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_ADDR_BITS = 6;
    localparam int REG_IDX_LSB = 3;
    localparam int REG_IDX_BITS = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_WIDTH = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_KERNEL_TOP = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_KERNEL_MIDDLE = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_KERNEL_BOTTOM = 3'd4;

    localparam logic [IMG_W_BITS-1:0] WIDTH_RESET = 11'd1024;
    localparam logic [IMG_H_BITS-1:0] HEIGHT_RESET = 16'd1;
    localparam logic [KROW_BITS-1:0] KERNEL_ZERO = 48'h0;
    localparam logic [KROW_BITS-1:0] KERNEL_MID_RESET = 48'h0000_0001_0000;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // Per-item control carried from the accept stage into the window stage
    typedef struct packed {
        logic is_pixel;
        logic col_zero;  // pixel: column 0; flush: center column 0
        logic last;      // last column of the row
        logic row_ge2;   // two real rows above exist
    } s1_ctl_t;

    // Results still owed by the item in the window stage
    typedef struct packed {
        logic a;  // interior result of a pixel
        logic b;  // right-edge result at row end
        logic f;  // flush result
    } job_pend_t;

    typedef struct packed {
        logic row_end;
        logic frame_end;
    } job_flags_t;

endpackage

// ===== design/c3ef_line_mem.sv =====
// Line buffer: one write port, two registered read ports, read-first.
// No package dependencies; instantiated twice by the top level.
module c3ef_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW = 10,
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== design/c3ef_window.sv =====
// Window stage: builds the 3x3 neighborhood from line-buffer read data and
// issues one convolution job per cycle while job_ready is high. Depends on c3ef_pkg.
module c3ef_window
    import c3ef_pkg::*;
#(
    parameter int PIXEL_BITS = 8,
    parameter int COL_W = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        load,
    input  s1_ctl_t                     load_ctl,
    input  job_pend_t                   load_pend,
    input  logic [COL_W-1:0]            load_addr,
    input  logic [PIXEL_BITS-1:0]       load_pixel,
    input  logic [PIXEL_BITS-1:0]       one_a,
    input  logic [PIXEL_BITS-1:0]       one_b,
    input  logic [PIXEL_BITS-1:0]       two_a,
    input  logic [PIXEL_BITS-1:0]       two_b,
    output logic                        s1_free,
    output logic                        wr_two_en,
    output logic [COL_W-1:0]            wr_two_addr,
    output logic [PIXEL_BITS-1:0]       wr_two_data,
    output logic                        job_valid,
    input  logic                        job_ready,
    output logic [TAPS*PIXEL_BITS-1:0]  job_pix,
    output job_flags_t                  job_flags
);

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  fresh_reg;
    s1_ctl_t               ctl_reg;
    job_pend_t             pend_reg;
    job_pend_t             pend_next;
    logic [COL_W-1:0]      addr_reg;
    logic [PIXEL_BITS-1:0] pixel_reg;

    // window columns [col][row]: col 0 left, row 0 top
    logic [PIXEL_BITS-1:0] win_reg [KSIZE][KSIZE];
    logic [PIXEL_BITS-1:0] win_next [KSIZE][KSIZE];
    logic [PIXEL_BITS-1:0] win_use [KSIZE][KSIZE];
    logic [PIXEL_BITS-1:0] job_cols [KSIZE][KSIZE];
    logic [PIXEL_BITS-1:0] new_col [KSIZE];

    // cached copy of the line-buffer entry at the next flush center column
    logic [COL_W-1:0]      held_addr_reg;
    logic [PIXEL_BITS-1:0] held_one_reg;
    logic [PIXEL_BITS-1:0] held_two_reg;

    logic [PIXEL_BITS-1:0] flush_a [KSIZE];
    logic [PIXEL_BITS-1:0] flush_b [KSIZE];
    logic [PIXEL_BITS-1:0] flush_m [KSIZE];
    logic [PIXEL_BITS-1:0] top_a;
    logic [PIXEL_BITS-1:0] top_b;
    logic [PIXEL_BITS-1:0] top_h;
    logic                  commit;
    logic                  flush_take;

    assign commit = s1_valid_reg && fresh_reg;

    always_comb begin
        top_a = ctl_reg.row_ge2 ? two_a : one_a;
        top_b = ctl_reg.row_ge2 ? two_b : one_b;
        top_h = ctl_reg.row_ge2 ? held_two_reg : held_one_reg;

        new_col[0] = top_a;
        new_col[1] = one_a;
        new_col[2] = pixel_reg;

        for (int r = 0; r < KSIZE; r++) begin
            for (int k = 0; k < KSIZE - 1; k++) begin
                win_next[k][r] = ctl_reg.col_zero ? new_col[r] : win_reg[k+1][r];
            end
            win_next[KSIZE-1][r] = new_col[r];
            for (int k = 0; k < KSIZE; k++) begin
                win_use[k][r] = fresh_reg ? win_next[k][r] : win_reg[k][r];
            end
        end

        flush_a[0] = top_a;
        flush_a[1] = one_a;
        flush_a[2] = one_a;
        flush_b[0] = top_b;
        flush_b[1] = one_b;
        flush_b[2] = one_b;
        for (int r = 0; r < KSIZE; r++) begin
            if (ctl_reg.col_zero) begin
                flush_m[r] = flush_a[r];
            end else if (ctl_reg.last) begin
                flush_m[r] = flush_b[r];
            end else begin
                flush_m[r] = (r == 0) ? top_h : held_one_reg;
            end
        end

        job_flags = '0;
        for (int r = 0; r < KSIZE; r++) begin
            if (pend_reg.a) begin
                job_cols[0][r] = win_use[0][r];
                job_cols[1][r] = win_use[1][r];
                job_cols[2][r] = win_use[2][r];
            end else if (pend_reg.b) begin
                // right edge replicates the last column
                job_cols[0][r] = win_use[1][r];
                job_cols[1][r] = win_use[2][r];
                job_cols[2][r] = win_use[2][r];
            end else begin
                job_cols[0][r] = flush_a[r];
                job_cols[1][r] = flush_m[r];
                job_cols[2][r] = flush_b[r];
            end
        end
        if (pend_reg.a) begin
            job_flags = '0;
        end else if (pend_reg.b) begin
            job_flags.row_end = 1'b1;
        end else begin
            job_flags.row_end = ctl_reg.last;
            job_flags.frame_end = ctl_reg.last;
        end

        for (int r = 0; r < KSIZE; r++) begin
            for (int k = 0; k < KSIZE; k++) begin
                job_pix[(r*KSIZE+k)*PIXEL_BITS +: PIXEL_BITS] = job_cols[k][r];
            end
        end
    end

    assign job_valid = s1_valid_reg && (pend_reg.a || pend_reg.b || pend_reg.f);
    assign flush_take = job_valid && job_ready && !ctl_reg.is_pixel;

    always_comb begin
        pend_next = pend_reg;
        if (job_valid && job_ready) begin
            if (pend_reg.a) begin
                pend_next.a = 1'b0;
            end else if (pend_reg.b) begin
                pend_next.b = 1'b0;
            end else begin
                pend_next.f = 1'b0;
            end
        end
        s1_valid_next = s1_valid_reg && (pend_next != '0);
    end

    assign s1_free = !s1_valid_next;

    // line_two takes the old line_one value of the same column
    assign wr_two_en = commit && ctl_reg.is_pixel;
    assign wr_two_addr = addr_reg;
    assign wr_two_data = one_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fresh_reg <= 1'b0;
            pend_reg <= '0;
            for (int k = 0; k < KSIZE; k++) begin
                for (int r = 0; r < KSIZE; r++) begin
                    win_reg[k][r] <= '0;
                end
            end
        end else begin
            if (commit && ctl_reg.is_pixel) begin
                for (int k = 0; k < KSIZE; k++) begin
                    for (int r = 0; r < KSIZE; r++) begin
                        win_reg[k][r] <= win_next[k][r];
                    end
                end
            end
            if (load) begin
                s1_valid_reg <= 1'b1;
                fresh_reg <= 1'b1;
                pend_reg <= load_pend;
            end else begin
                s1_valid_reg <= s1_valid_next;
                fresh_reg <= 1'b0;
                pend_reg <= pend_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ctl_reg <= load_ctl;
            addr_reg <= load_addr;
            pixel_reg <= load_pixel;
        end
        if (commit && ctl_reg.is_pixel) begin
            if (addr_reg == held_addr_reg) begin
                held_one_reg <= pixel_reg;
                held_two_reg <= one_a;
            end
        end else if (flush_take && !ctl_reg.last) begin
            // refill only once this flush job is gone; it reads the cache until then
            held_addr_reg <= addr_reg;
            held_one_reg <= one_b;
            held_two_reg <= two_b;
        end
    end

endmodule

// ===== design/c3ef_mac.sv =====
// Multiply-accumulate pipeline: job register, nine products, row sums and
// the output register of the result channel. Depends on c3ef_pkg.
module c3ef_mac
    import c3ef_pkg::*;
#(
    parameter int PIXEL_BITS = 8,
    parameter int COEF_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [KROW_BITS-1:0]              kernel_rows [KSIZE],
    input  logic                              job_valid,
    output logic                              job_ready,
    input  logic [TAPS*PIXEL_BITS-1:0]        job_pix,
    input  job_flags_t                        job_flags,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [OUT_BITS-1:0]        m_filtered,
    output logic                              m_row_end,
    output logic                              m_frame_end
);

    localparam int MW = PIXEL_BITS + COEF_BITS + 1;
    localparam int ACC_W = (MW + 4 > OUT_BITS) ? MW + 4 : OUT_BITS;

    logic advance;

    logic                        jv_reg;
    logic [TAPS*PIXEL_BITS-1:0]  jpix_reg;
    job_flags_t                  jflags_reg;

    logic                        pv_reg;
    logic signed [MW-1:0]        prod_reg [TAPS];
    logic signed [MW-1:0]        prod_next [TAPS];
    job_flags_t                  pflags_reg;

    logic                        rv_reg;
    logic signed [ACC_W-1:0]     rsum_reg [KSIZE];
    logic signed [ACC_W-1:0]     rsum_next [KSIZE];
    job_flags_t                  rflags_reg;

    logic signed [ACC_W-1:0]     total;
    logic signed [COEF_BITS-1:0] coef [TAPS];

    assign advance = !m_valid || m_ready;
    assign job_ready = advance;

    always_comb begin
        for (int r = 0; r < KSIZE; r++) begin
            for (int k = 0; k < KSIZE; k++) begin
                coef[r*KSIZE+k] = kernel_rows[r][COEF_SLOT*k +: COEF_BITS];
            end
        end
        for (int i = 0; i < TAPS; i++) begin
            prod_next[i] = $signed({1'b0, jpix_reg[i*PIXEL_BITS +: PIXEL_BITS]}) * coef[i];
        end
        for (int r = 0; r < KSIZE; r++) begin
            rsum_next[r] = ACC_W'(prod_reg[r*KSIZE]) + ACC_W'(prod_reg[r*KSIZE+1])
                         + ACC_W'(prod_reg[r*KSIZE+2]);
        end
        total = rsum_reg[0] + rsum_reg[1] + rsum_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jv_reg <= 1'b0;
            pv_reg <= 1'b0;
            rv_reg <= 1'b0;
            m_valid <= 1'b0;
        end else if (advance) begin
            jv_reg <= job_valid;
            pv_reg <= jv_reg;
            rv_reg <= pv_reg;
            m_valid <= rv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            jpix_reg <= job_pix;
            jflags_reg <= job_flags;
            for (int i = 0; i < TAPS; i++) begin
                prod_reg[i] <= prod_next[i];
            end
            pflags_reg <= jflags_reg;
            for (int r = 0; r < KSIZE; r++) begin
                rsum_reg[r] <= rsum_next[r];
            end
            rflags_reg <= pflags_reg;
            // sum wraps to the output width
            m_filtered <= total[OUT_BITS-1:0];
            m_row_end <= rflags_reg.row_end;
            m_frame_end <= rflags_reg.frame_end;
        end
    end

endmodule

// ===== design/conv3x3_clamp_edge_filter.sv =====
// 3x3 convolution with replicated borders over a raster pixel stream.
// Path: a transfer's result leaves on m_* via the window-stage, job, product, row-sum
// and output registers; a row end's second result follows the first. m_ready stalls add
// to both. Throughput: one item per cycle unless m_ready stalls; a row's last pixel
// blocks s_ready for its two results, sharing the single multiply-accumulate pipeline.
// Reset: counters and window cleared, width 1024, height 1, identity kernel;
// the line buffers are not cleared and need no clearing pass.
module conv3x3_clamp_edge_filter
    import c3ef_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int PIXEL_BITS = 8,
    parameter int COEF_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [CFG_ADDR_BITS-1:0]   paddr,
    input  logic [CFG_DATA_BITS-1:0]   pwdata,
    output logic [CFG_DATA_BITS-1:0]   prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_kind,
    input  logic [PIXEL_BITS-1:0]      s_pixel,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [OUT_BITS-1:0] m_filtered,
    output logic                       m_row_end,
    output logic                       m_frame_end
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WC = (COL_W + 1 > IMG_W_BITS) ? COL_W + 1 : IMG_W_BITS;

    // configuration
    logic [IMG_W_BITS-1:0]   image_width_reg;
    logic [IMG_H_BITS-1:0]   image_height_reg;
    logic [KROW_BITS-1:0]    kernel_reg [KSIZE];
    logic [REG_IDX_BITS-1:0] reg_idx;
    logic                    cfg_we;

    // frame position
    logic [COL_W-1:0]      column_count_reg;
    logic [IMG_H_BITS-1:0] row_count_reg;
    logic [COL_W-1:0]      flush_column_reg;

    logic [WC-1:0]         iw_ext;
    logic [WC-1:0]         w_eff;
    logic [IMG_H_BITS-1:0] h_eff;
    logic                  row_live;
    logic                  pix_last;
    logic [WC-1:0]         ctr_ext;
    logic [COL_W-1:0]      ctr;
    logic                  fl_last;
    logic [COL_W-1:0]      idx_left;
    logic [COL_W-1:0]      idx_right;

    logic      take;
    logic      do_pix;
    logic      do_flush;
    logic      load;
    s1_ctl_t   load_ctl;
    job_pend_t load_pend;
    logic [COL_W-1:0] load_addr;
    logic [COL_W-1:0] rd_addr_a;
    logic      s1_free;

    logic [PIXEL_BITS-1:0] one_a;
    logic [PIXEL_BITS-1:0] one_b;
    logic [PIXEL_BITS-1:0] two_a_raw;
    logic [PIXEL_BITS-1:0] two_b_raw;
    logic [PIXEL_BITS-1:0] two_a;
    logic [PIXEL_BITS-1:0] two_b;

    logic                  wr_two_en;
    logic [COL_W-1:0]      wr_two_addr;
    logic [PIXEL_BITS-1:0] wr_two_data;
    logic                  fwd_a_reg;
    logic                  fwd_b_reg;
    logic [PIXEL_BITS-1:0] fwd_data_reg;

    logic                       job_valid;
    logic                       job_ready;
    logic [TAPS*PIXEL_BITS-1:0] job_pix;
    job_flags_t                 job_flags;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign reg_idx = paddr[REG_IDX_LSB +: REG_IDX_BITS];
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            kernel_reg[0] <= KERNEL_ZERO;
            kernel_reg[1] <= KERNEL_MID_RESET;
            kernel_reg[2] <= KERNEL_ZERO;
        end else if (cfg_we) begin
            case (reg_idx)
                REG_IMAGE_WIDTH: image_width_reg <= pwdata[IMG_W_BITS-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[IMG_H_BITS-1:0];
                REG_KERNEL_TOP: kernel_reg[0] <= pwdata[KROW_BITS-1:0];
                REG_KERNEL_MIDDLE: kernel_reg[1] <= pwdata[KROW_BITS-1:0];
                REG_KERNEL_BOTTOM: kernel_reg[2] <= pwdata[KROW_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_IMAGE_WIDTH: prdata = CFG_DATA_BITS'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = CFG_DATA_BITS'(image_height_reg);
            REG_KERNEL_TOP: prdata = CFG_DATA_BITS'(kernel_reg[0]);
            REG_KERNEL_MIDDLE: prdata = CFG_DATA_BITS'(kernel_reg[1]);
            REG_KERNEL_BOTTOM: prdata = CFG_DATA_BITS'(kernel_reg[2]);
            default: prdata = '0;
        endcase
    end

    // ---------------- accept stage ----------------
    always_comb begin
        iw_ext = WC'(image_width_reg);
        if (iw_ext == '0) begin
            w_eff = WC'(1);
        end else if (iw_ext > WC'(MAX_WIDTH)) begin
            w_eff = WC'(MAX_WIDTH);
        end else begin
            w_eff = iw_ext;
        end
        h_eff = (image_height_reg == '0) ? IMG_H_BITS'(1) : image_height_reg;
        row_live = row_count_reg < h_eff;

        pix_last = (WC'(column_count_reg) + WC'(1)) >= w_eff;

        // flush center saturates at the last column
        ctr_ext = (WC'(flush_column_reg) >= w_eff) ? (w_eff - WC'(1))
                                                   : WC'(flush_column_reg);
        ctr = ctr_ext[COL_W-1:0];
        fl_last = (ctr_ext + WC'(1)) >= w_eff;
        idx_left = (ctr == '0) ? '0 : ctr - COL_W'(1);
        idx_right = fl_last ? ctr : ctr + COL_W'(1);
    end

    assign s_ready = s1_free;
    assign take = s_valid && s_ready;
    assign do_pix = take && (s_kind == KIND_PIXEL) && row_live;
    assign do_flush = take && (s_kind == KIND_FLUSH) && !row_live;
    assign load = do_pix || do_flush;

    always_comb begin
        load_ctl.is_pixel = (s_kind == KIND_PIXEL);
        load_ctl.row_ge2 = row_count_reg >= IMG_H_BITS'(2);
        load_pend.a = 1'b0;
        load_pend.b = 1'b0;
        load_pend.f = 1'b0;
        if (s_kind == KIND_PIXEL) begin
            load_ctl.col_zero = (column_count_reg == '0);
            load_ctl.last = pix_last;
            load_pend.a = (row_count_reg != '0) && (column_count_reg != '0);
            load_pend.b = (row_count_reg != '0) && pix_last;
            load_addr = column_count_reg;
            rd_addr_a = column_count_reg;
        end else begin
            load_ctl.col_zero = (ctr == '0);
            load_ctl.last = fl_last;
            load_pend.f = 1'b1;
            load_addr = ctr + COL_W'(1);
            rd_addr_a = idx_left;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg <= '0;
            flush_column_reg <= '0;
        end else if (do_pix) begin
            if (pix_last) begin
                column_count_reg <= '0;
                row_count_reg <= row_count_reg + IMG_H_BITS'(1);
            end else begin
                column_count_reg <= column_count_reg + COL_W'(1);
            end
        end else if (do_flush) begin
            if (fl_last) begin
                flush_column_reg <= '0;
                row_count_reg <= '0;
                column_count_reg <= '0;
            end else begin
                flush_column_reg <= ctr + COL_W'(1);
            end
        end
    end

    // line_two is written from the window-stage register after its read; forward a colliding write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_a_reg <= 1'b0;
            fwd_b_reg <= 1'b0;
        end else if (load) begin
            fwd_a_reg <= wr_two_en && (wr_two_addr == rd_addr_a);
            fwd_b_reg <= wr_two_en && (wr_two_addr == idx_right);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            fwd_data_reg <= wr_two_data;
        end
    end

    assign two_a = fwd_a_reg ? fwd_data_reg : two_a_raw;
    assign two_b = fwd_b_reg ? fwd_data_reg : two_b_raw;

    // ---------------- line buffers ----------------
    c3ef_line_mem #(
        .DEPTH(MAX_WIDTH),
        .AW(COL_W),
        .DW(PIXEL_BITS)
    ) u_line_one (
        .aclk(aclk),
        .we(do_pix),
        .waddr(column_count_reg),
        .wdata(s_pixel),
        .re(load),
        .raddr_a(rd_addr_a),
        .raddr_b(idx_right),
        .rdata_a(one_a),
        .rdata_b(one_b)
    );

    c3ef_line_mem #(
        .DEPTH(MAX_WIDTH),
        .AW(COL_W),
        .DW(PIXEL_BITS)
    ) u_line_two (
        .aclk(aclk),
        .we(wr_two_en),
        .waddr(wr_two_addr),
        .wdata(wr_two_data),
        .re(load),
        .raddr_a(rd_addr_a),
        .raddr_b(idx_right),
        .rdata_a(two_a_raw),
        .rdata_b(two_b_raw)
    );

    // ---------------- window and arithmetic ----------------
    c3ef_window #(
        .PIXEL_BITS(PIXEL_BITS),
        .COL_W(COL_W)
    ) u_window (
        .aclk(aclk),
        .aresetn(aresetn),
        .load(load),
        .load_ctl(load_ctl),
        .load_pend(load_pend),
        .load_addr(load_addr),
        .load_pixel(s_pixel),
        .one_a(one_a),
        .one_b(one_b),
        .two_a(two_a),
        .two_b(two_b),
        .s1_free(s1_free),
        .wr_two_en(wr_two_en),
        .wr_two_addr(wr_two_addr),
        .wr_two_data(wr_two_data),
        .job_valid(job_valid),
        .job_ready(job_ready),
        .job_pix(job_pix),
        .job_flags(job_flags)
    );

    c3ef_mac #(
        .PIXEL_BITS(PIXEL_BITS),
        .COEF_BITS(COEF_BITS)
    ) u_mac (
        .aclk(aclk),
        .aresetn(aresetn),
        .kernel_rows(kernel_reg),
        .job_valid(job_valid),
        .job_ready(job_ready),
        .job_pix(job_pix),
        .job_flags(job_flags),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_filtered(m_filtered),
        .m_row_end(m_row_end),
        .m_frame_end(m_frame_end)
    );

endmodule
